/* sv/dual_pol_baseline_correlator_macros.svh */
// assertion macros for the dual polarization baseline correlator
// each macro expects clk and rst to be visible where it is used
`ifndef DUAL_POL_BASELINE_CORRELATOR_MACROS_SVH
`define DUAL_POL_BASELINE_CORRELATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DPBC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpbc: same-cycle check failed");

// next-cycle implication
`define DPBC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpbc: next-cycle check failed");

`else

`define DPBC_ASSERT_IMP(label, ante, cons)
`define DPBC_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* sv/dpbc_pkg.sv */
`timescale 1ns / 1ps

package dpbc_pkg;

  // fixed port widths
  localparam int IN_W       = 16;
  localparam int CFG_LEN_W  = 11;
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  // parameter defaults
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int ACC_BITS_DEF        = 48;
  localparam int MAX_INTEGRATION_DEF = 1024;

  // integration length after reset
  localparam logic [CFG_LEN_W-1:0] LEN_RESET = CFG_LEN_W'(1024);

  // register word indexes
  typedef enum logic [0:0] {
    REG_INTEGRATION_LENGTH = 1'b0,
    REG_UNMAPPED           = 1'b1
  } reg_idx_t;

endpackage

/* sv/dpbc_if.sv */
`timescale 1ns / 1ps

// one time sample of both stations, both polarizations
interface dpbc_sample_if import dpbc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] a_x_re;
  logic [IN_W-1:0] a_x_im;
  logic [IN_W-1:0] a_y_re;
  logic [IN_W-1:0] a_y_im;
  logic [IN_W-1:0] b_x_re;
  logic [IN_W-1:0] b_x_im;
  logic [IN_W-1:0] b_y_re;
  logic [IN_W-1:0] b_y_im;

  modport source (
    output valid, a_x_re, a_x_im, a_y_re, a_y_im, b_x_re, b_x_im, b_y_re, b_y_im,
    input  ready
  );
  modport sink (
    input  valid, a_x_re, a_x_im, a_y_re, a_y_im, b_x_re, b_x_im, b_y_re, b_y_im,
    output ready
  );
endinterface

// one set of integrated visibilities
interface dpbc_vis_if import dpbc_pkg::*; #(
  parameter int ACC_W = ACC_BITS_DEF
) ();
  logic             valid;
  logic             ready;
  logic [ACC_W-1:0] xx_re;
  logic [ACC_W-1:0] xx_im;
  logic [ACC_W-1:0] xy_re;
  logic [ACC_W-1:0] xy_im;
  logic [ACC_W-1:0] yx_re;
  logic [ACC_W-1:0] yx_im;
  logic [ACC_W-1:0] yy_re;
  logic [ACC_W-1:0] yy_im;

  modport source (
    output valid, xx_re, xx_im, xy_re, xy_im, yx_re, yx_im, yy_re, yy_im,
    input  ready
  );
  modport sink (
    input  valid, xx_re, xx_im, xy_re, xy_im, yx_re, yx_im, yy_re, yy_im,
    output ready
  );
endinterface

/* sv/dual_pol_baseline_correlator.sv */
`timescale 1ns / 1ps
`include "dual_pol_baseline_correlator_macros.svh"

// dual polarization baseline correlator
// samples: one request per time sample, both stations, X and Y, complex
//   16-bit fields, low SAMPLE_BITS bits used and sign extended
// vis: one request per integration, the four products aP * conj(bQ) summed
//   into saturating ACC_BITS accumulators, which clear after each result
// apb: integration_length at byte address 0, 0 acts as 1, values above
//   MAX_INTEGRATION act as MAX_INTEGRATION; write only while idle
// throughput: one sample per cycle, set by the input register, a product
//   stage and the accumulator stage, each taking a request every cycle unless stalled
// path: the last sample of an integration passes the input register and the
//   product stage, and its sum is loaded into the result register on vis
// stall: while a result waits on vis, samples keep flowing into the
//   accumulators; only a sample that closes the next integration waits in
//   the product stage, and the input backs up behind it
// reset: accumulators and sample count clear, integration_length is 1024,
//   all stages empty
module dual_pol_baseline_correlator import dpbc_pkg::*; #(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int ACC_BITS        = ACC_BITS_DEF,
  parameter int MAX_INTEGRATION = MAX_INTEGRATION_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  dpbc_sample_if.sink           samples,
  dpbc_vis_if.source            vis,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int TERM_W = PROD_W + 1;
  localparam int SUM_W  = ((ACC_BITS > TERM_W) ? ACC_BITS : TERM_W) + 1;
  localparam int CNT_W  = $clog2(MAX_INTEGRATION + 1);
  localparam int LEN_W  = (CNT_W > CFG_LEN_W) ? CNT_W : CFG_LEN_W;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_INTEGRATION);
  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

  // configuration register
  logic [CFG_LEN_W-1:0] integration_length;
  reg_idx_t             reg_idx;

  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      integration_length <= LEN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == REG_INTEGRATION_LENGTH) begin
      integration_length <= pwdata[CFG_LEN_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INTEGRATION_LENGTH: prdata = APB_DATA_W'(integration_length);
      default:                prdata = '0;
    endcase
  end

  // pipeline control
  logic v1, v2;
  logic last;
  logic stall_acc, acc_go, emit;
  logic s2_free, s1_free;

  assign stall_acc     = v2 && last && vis.valid && !vis.ready;
  assign acc_go        = v2 && !stall_acc;
  assign emit          = acc_go && last;
  assign s2_free       = !v2 || acc_go;
  assign s1_free       = !v1 || s2_free;
  assign samples.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (s1_free) begin
        v1 <= samples.valid;
      end
      if (s2_free) begin
        v2 <= v1;
      end
    end
  end

  // input register: a_x re/im, a_y re/im, b_x re/im, b_y re/im
  logic [IN_W-1:0]               raw [8];
  logic signed [SAMPLE_BITS-1:0] smp [8];

  assign raw[0] = samples.a_x_re;
  assign raw[1] = samples.a_x_im;
  assign raw[2] = samples.a_y_re;
  assign raw[3] = samples.a_y_im;
  assign raw[4] = samples.b_x_re;
  assign raw[5] = samples.b_x_im;
  assign raw[6] = samples.b_y_re;
  assign raw[7] = samples.b_y_im;

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      for (int i = 0; i < 8; i++) begin
        smp[i] <= $signed(raw[i][SAMPLE_BITS-1:0]);
      end
    end
  end

  // product stage: one complex conjugate product per polarization pair
  logic signed [TERM_W-1:0] term_next [8];
  logic signed [TERM_W-1:0] term      [8];

  for (genvar k = 0; k < 4; k++) begin : g_pair
    localparam int PA = k / 2;
    localparam int QB = k % 2;
    logic signed [PROD_W-1:0] rr, ii, ir, ri;

    assign rr = smp[2*PA]     * smp[4 + 2*QB];
    assign ii = smp[2*PA + 1] * smp[4 + 2*QB + 1];
    assign ir = smp[2*PA + 1] * smp[4 + 2*QB];
    assign ri = smp[2*PA]     * smp[4 + 2*QB + 1];

    assign term_next[2*k]     = TERM_W'(rr) + TERM_W'(ii);
    assign term_next[2*k + 1] = TERM_W'(ir) - TERM_W'(ri);
  end

  always_ff @(posedge clk) begin
    if (s2_free && v1) begin
      term <= term_next;
    end
  end

  // effective integration length and end of integration
  logic [CNT_W-1:0] sample_count;
  logic [LEN_W-1:0] len_cfg, len_eff;
  logic [LEN_W:0]   count_inc;

  assign len_cfg   = LEN_W'(integration_length);
  assign count_inc = (LEN_W + 1)'(sample_count) + 1'b1;

  always_comb begin
    priority if (len_cfg == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_cfg > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = len_cfg;
    end
  end

  assign last = count_inc >= (LEN_W + 1)'(len_eff);

  // saturating accumulate
  logic signed [ACC_BITS-1:0] acc      [8];
  logic signed [ACC_BITS-1:0] acc_next [8];

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int j = 0; j < 8; j++) begin
      sum = SUM_W'(acc[j]) + SUM_W'(term[j]);
      priority if (sum > ACC_MAX) begin
        acc_next[j] = ACC_MAX[ACC_BITS-1:0];
      end else if (sum < ACC_MIN) begin
        acc_next[j] = ACC_MIN[ACC_BITS-1:0];
      end else begin
        acc_next[j] = sum[ACC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      for (int j = 0; j < 8; j++) begin
        acc[j] <= '0;
      end
    end else if (acc_go) begin
      if (last) begin
        sample_count <= '0;
        for (int j = 0; j < 8; j++) begin
          acc[j] <= '0;
        end
      end else begin
        sample_count <= count_inc[CNT_W-1:0];
        acc          <= acc_next;
      end
    end
  end

  // result register
  logic                       ov;
  logic signed [ACC_BITS-1:0] out_acc [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit) begin
      ov <= 1'b1;
    end else if (vis.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_acc <= acc_next;
    end
  end

  assign vis.valid = ov;
  assign vis.xx_re = out_acc[0];
  assign vis.xx_im = out_acc[1];
  assign vis.xy_re = out_acc[2];
  assign vis.xy_im = out_acc[3];
  assign vis.yx_re = out_acc[4];
  assign vis.yx_im = out_acc[5];
  assign vis.yy_re = out_acc[6];
  assign vis.yy_im = out_acc[7];

  // checks
  `DPBC_ASSERT_NXT(a_emit_shows_result, emit, vis.valid)
  `DPBC_ASSERT_NXT(a_emit_clears_state, emit, (sample_count == '0) && (acc[0] == '0))
  `DPBC_ASSERT_NXT(a_stall_keeps_item, stall_acc, v2)
  `DPBC_ASSERT_IMP(a_stall_needs_full_out, stall_acc, ov && !emit)

endmodule
